>>> rtl/id3_pkg.sv
package id3_pkg;

	// Parse phases of the front end.
	typedef enum logic [2:0] {
		PH_HDR,
		PH_FHDR,
		PH_ENC,
		PH_BODY,
		PH_SKIP,
		PH_PASS,
		PH_STOP
	} phase_t;

	// Result kinds.
	localparam logic [2:0] KIND_HEADER  = 3'd0;
	localparam logic [2:0] KIND_FSTART  = 3'd1;
	localparam logic [2:0] KIND_PAYLOAD = 3'd2;
	localparam logic [2:0] KIND_PAD     = 3'd3;
	localparam logic [2:0] KIND_TAGEND  = 3'd4;
	localparam logic [2:0] KIND_NOTAG   = 3'd5;
	localparam logic [2:0] KIND_BADENC  = 3'd6;
	localparam logic [2:0] KIND_PASS    = 3'd7;

	localparam logic [7:0] MAX_ENCODING  = 8'h03;
	localparam logic [7:0] TAG_VERSION3  = 8'h03;
	localparam logic [3:0] HDR_LAST_IDX  = 4'd9;
	localparam logic [3:0] IDX_VERSION   = 4'd3;
	localparam logic [3:0] IDX_REVISION  = 4'd4;
	localparam logic [3:0] IDX_FLAGS     = 4'd5;
	localparam logic [3:0] IDX_ID_END    = 4'd4;
	localparam logic [3:0] IDX_SIZE_END  = 4'd8;
	localparam logic [7:0] SYNCSAFE_MASK = 8'h7f;

	// One result item as it travels through the queue.
	typedef struct packed {
		logic [2:0]  kind;
		logic [7:0]  version;
		logic [7:0]  revision;
		logic [2:0]  header_flags;
		logic [31:0] size_value;
		logic [31:0] frame_ident;
		logic [1:0]  text_encoding;
		logic [7:0]  out_byte;
		logic        last_of_frame;
	} res_t;

	function automatic logic [7:0] magic_letter(input logic [1:0] idx);
		logic [7:0] ch;
		unique case (idx)
			2'd0:    ch = 8'h49; // 'I'
			2'd1:    ch = 8'h44; // 'D'
			default: ch = 8'h33; // '3'
		endcase
		return ch;
	endfunction

	// Prefix bytes dropped ahead of the payload, by text encoding.
	function automatic logic [1:0] prefix_len(input logic [1:0] enc);
		logic [1:0] n;
		unique case (enc)
			2'd0:    n = 2'd0;
			2'd1:    n = 2'd2;
			2'd2:    n = 2'd2;
			default: n = 2'd3;
		endcase
		return n;
	endfunction

endpackage

>>> rtl/id3_front.sv
module id3_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                accept,
	input  logic [7:0]          data_byte,
	input  logic                restart,
	input  logic                cfg_we,
	input  logic                cfg_data,
	output logic                res_valid,
	output id3_pkg::res_t       res
);

	id3_pkg::phase_t phase_q, phase_n;
	logic [3:0]  idx_q, idx_n;
	logic [27:0] tag_q, tag_n;
	logic [31:0] frem_q, frem_n;
	logic [31:0] fid_q, fid_n;
	logic [31:0] fsize_q, fsize_n;
	logic [1:0]  enc_q, enc_n;
	logic [1:0]  pre_q, pre_n;
	logic [7:0]  ver_q, ver_n;
	logic [7:0]  rev_q, rev_n;
	logic [2:0]  flg_q, flg_n;
	logic        idm_q, idm_n;
	logic        emit_q;

	logic        have, with_frame, with_byte, last, payload_out, in_tag;
	logic [2:0]  kind;
	logic [31:0] sz;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			emit_q <= 1'b1;
		end else if (cfg_we) begin
			emit_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= id3_pkg::PH_HDR;
			idx_q   <= '0;
			tag_q   <= '0;
			frem_q  <= '0;
			fid_q   <= '0;
			fsize_q <= '0;
			enc_q   <= '0;
			pre_q   <= '0;
			ver_q   <= '0;
			rev_q   <= '0;
			flg_q   <= '0;
			idm_q   <= 1'b1;
		end else if (accept) begin
			phase_q <= phase_n;
			idx_q   <= idx_n;
			tag_q   <= tag_n;
			frem_q  <= frem_n;
			fid_q   <= fid_n;
			fsize_q <= fsize_n;
			enc_q   <= enc_n;
			pre_q   <= pre_n;
			ver_q   <= ver_n;
			rev_q   <= rev_n;
			flg_q   <= flg_n;
			idm_q   <= idm_n;
		end
	end

	always_comb begin
		// start from the held state, or from a cleared one on restart
		if (restart) begin
			phase_n = id3_pkg::PH_HDR;
			idx_n   = '0;
			tag_n   = '0;
			frem_n  = '0;
			fid_n   = '0;
			fsize_n = '0;
			enc_n   = '0;
			pre_n   = '0;
			ver_n   = '0;
			rev_n   = '0;
			flg_n   = '0;
			idm_n   = 1'b1;
		end else begin
			phase_n = phase_q;
			idx_n   = idx_q;
			tag_n   = tag_q;
			frem_n  = frem_q;
			fid_n   = fid_q;
			fsize_n = fsize_q;
			enc_n   = enc_q;
			pre_n   = pre_q;
			ver_n   = ver_q;
			rev_n   = rev_q;
			flg_n   = flg_q;
			idm_n   = idm_q;
		end
		have        = 1'b0;
		with_frame  = 1'b0;
		with_byte   = 1'b0;
		last        = 1'b0;
		payload_out = 1'b0;
		in_tag      = 1'b0;
		kind        = id3_pkg::KIND_HEADER;
		sz          = '0;

		unique case (phase_n)
			id3_pkg::PH_HDR: begin
				if (idx_n < id3_pkg::IDX_VERSION) begin
					if (data_byte != id3_pkg::magic_letter(idx_n[1:0]))
						idm_n = 1'b0;
				end else if (idx_n == id3_pkg::IDX_VERSION) begin
					ver_n = data_byte;
				end else if (idx_n == id3_pkg::IDX_REVISION) begin
					rev_n = data_byte;
				end else if (idx_n == id3_pkg::IDX_FLAGS) begin
					flg_n = data_byte[7:5];
				end else begin
					tag_n = {tag_n[20:0], data_byte[6:0] & id3_pkg::SYNCSAFE_MASK[6:0]};
				end
				if (idx_n >= id3_pkg::HDR_LAST_IDX) begin
					idx_n = '0;
					have  = 1'b1;
					if (!idm_n) begin
						kind    = id3_pkg::KIND_NOTAG;
						phase_n = id3_pkg::PH_PASS;
					end else begin
						kind = id3_pkg::KIND_HEADER;
						sz   = {4'd0, tag_n};
						if (tag_n == '0)
							phase_n = id3_pkg::PH_PASS;
						else if (ver_n == id3_pkg::TAG_VERSION3)
							phase_n = id3_pkg::PH_FHDR;
						else
							phase_n = id3_pkg::PH_SKIP;
					end
				end else begin
					idx_n = idx_n + 4'd1;
				end
			end
			id3_pkg::PH_FHDR: begin
				in_tag = 1'b1;
				if (idx_n < id3_pkg::IDX_ID_END)
					fid_n = {fid_n[23:0], data_byte};
				else if (idx_n < id3_pkg::IDX_SIZE_END)
					fsize_n = {fsize_n[23:0], data_byte};
				if (idx_n >= id3_pkg::HDR_LAST_IDX) begin
					idx_n = '0;
					if (fsize_n == '0) begin
						kind       = id3_pkg::KIND_PAD;
						have       = 1'b1;
						with_frame = 1'b1;
						phase_n    = id3_pkg::PH_SKIP;
					end else begin
						phase_n = id3_pkg::PH_ENC;
					end
				end else begin
					idx_n = idx_n + 4'd1;
				end
			end
			id3_pkg::PH_ENC: begin
				if (data_byte > id3_pkg::MAX_ENCODING) begin
					kind       = id3_pkg::KIND_BADENC;
					have       = 1'b1;
					with_frame = 1'b1;
					with_byte  = 1'b1;
					phase_n    = id3_pkg::PH_STOP;
				end else begin
					in_tag     = 1'b1;
					enc_n      = data_byte[1:0];
					pre_n      = id3_pkg::prefix_len(data_byte[1:0]);
					frem_n     = fsize_n - 32'd1;
					kind       = id3_pkg::KIND_FSTART;
					sz         = fsize_n;
					have       = 1'b1;
					with_frame = 1'b1;
					phase_n    = (frem_n == '0) ? id3_pkg::PH_FHDR : id3_pkg::PH_BODY;
				end
			end
			id3_pkg::PH_BODY: begin
				in_tag = 1'b1;
				if (frem_n != '0)
					frem_n = frem_n - 32'd1;
				if (pre_n != '0) begin
					pre_n = pre_n - 2'd1;
				end else if (emit_q) begin
					kind        = id3_pkg::KIND_PAYLOAD;
					have        = 1'b1;
					with_frame  = 1'b1;
					with_byte   = 1'b1;
					payload_out = 1'b1;
					last        = (frem_n == '0);
				end
				if (frem_n == '0) begin
					idx_n   = '0;
					phase_n = id3_pkg::PH_FHDR;
				end
			end
			id3_pkg::PH_SKIP: begin
				in_tag = 1'b1;
			end
			id3_pkg::PH_PASS: begin
				kind      = id3_pkg::KIND_PASS;
				have      = 1'b1;
				with_byte = 1'b1;
			end
			default: begin
			end
		endcase

		// running tag count: the byte that uses it up ends the tag
		if (in_tag) begin
			if (tag_n != '0)
				tag_n = tag_n - 28'd1;
			if (tag_n == '0) begin
				kind       = id3_pkg::KIND_TAGEND;
				have       = 1'b1;
				with_frame = 1'b1;
				with_byte  = 1'b1;
				sz         = '0;
				last       = payload_out;
				phase_n    = id3_pkg::PH_PASS;
			end
		end
	end

	assign res_valid         = accept && have;
	assign res.kind          = kind;
	assign res.version       = ver_n;
	assign res.revision      = rev_n;
	assign res.header_flags  = flg_n;
	assign res.size_value    = sz;
	assign res.frame_ident   = with_frame ? fid_n : '0;
	assign res.text_encoding = with_frame ? enc_n : '0;
	assign res.out_byte      = with_byte ? data_byte : '0;
	assign res.last_of_frame = last;

endmodule

>>> rtl/id3_queue.sv
module id3_queue #(
	parameter int DEPTH = 4
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr_en,
	input  id3_pkg::res_t wr_data,
	input  logic          rd_en,
	output id3_pkg::res_t rd_data,
	output logic          full,
	output logic          empty
);

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	id3_pkg::res_t     slot_q [DEPTH];
	logic [PW-1:0]     wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]     count_q;
	logic              do_wr, do_rd;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr)
			slot_q[wr_ptr_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr)
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			if (do_rd)
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			if (do_wr && !do_rd)
				count_q <= count_q + CW'(1);
			else if (do_rd && !do_wr)
				count_q <= count_q - CW'(1);
		end
	end

endmodule

>>> rtl/id3v2_tag_parser.sv
// ID3v2 tag parser: takes a file one byte per item and reports the tag header,
// frame starts, payload bytes, padding and tag end, then passes later bytes on.
// Input channel: present data_byte/restart with push; the byte is taken on a
// clock edge with push high and full low. restart marks the first byte of a
// new file and clears all parse state (emit_payload is kept).
// Result channel: while empty is low the oldest result sits on the result
// ports; pop takes it. A byte yields zero or one result.
// Configuration: cfg_we writes cfg_data into emit_payload at the clock edge;
// write it only while no bytes are in flight.
// Results are queued as their bytes are taken and shown in order of arrival.
// Throughput: one byte per cycle while full is low; the front end updates its
// parse state per accepted byte and the DEPTH-entry queue absorbs pop stalls.
// When the receiver stalls, results pile up in the queue; once it holds
// DEPTH results, full rises and input is held until a pop frees a slot.
// Reset clears the parser to header collection, empties the queue and sets
// emit_payload to 1.
module id3v2_tag_parser #(
	parameter int DEPTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [7:0]  data_byte,
	input  logic        restart,
	input  logic        cfg_we,
	input  logic        cfg_data,
	output logic        empty,
	input  logic        pop,
	output logic [2:0]  kind,
	output logic [7:0]  version,
	output logic [7:0]  revision,
	output logic [2:0]  header_flags,
	output logic [31:0] size_value,
	output logic [31:0] frame_ident,
	output logic [1:0]  text_encoding,
	output logic [7:0]  out_byte,
	output logic        last_of_frame
);

	logic          accept;
	logic          res_valid;
	id3_pkg::res_t res;
	id3_pkg::res_t head;

	// take a byte only while the queue has room for its result
	assign accept = push && !full;

	id3_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.data_byte (data_byte),
		.restart   (restart),
		.cfg_we    (cfg_we),
		.cfg_data  (cfg_data),
		.res_valid (res_valid),
		.res       (res)
	);

	// hold results until the receiver pops them
	id3_queue #(
		.DEPTH (DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (res_valid),
		.wr_data (res),
		.rd_en   (pop),
		.rd_data (head),
		.full    (full),
		.empty   (empty)
	);

	assign kind          = head.kind;
	assign version       = head.version;
	assign revision      = head.revision;
	assign header_flags  = head.header_flags;
	assign size_value    = head.size_value;
	assign frame_ident   = head.frame_ident;
	assign text_encoding = head.text_encoding;
	assign out_byte      = head.out_byte;
	assign last_of_frame = head.last_of_frame;

`ifndef NO_ASSERTIONS
	// a produced result must be waiting in the next cycle
	a_result_queued: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |=> !empty)
		else $error("result lost on its way into the queue");

	// the last mark only goes with a payload byte or a tag end
	a_last_kind: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && last_of_frame) |->
		(kind == id3_pkg::KIND_PAYLOAD || kind == id3_pkg::KIND_TAGEND))
		else $error("last_of_frame on a wrong kind");

	// only header and frame start carry a size
	a_size_kind: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && size_value != '0) |->
		(kind == id3_pkg::KIND_HEADER || kind == id3_pkg::KIND_FSTART))
		else $error("size_value set on a wrong kind");

	// a byte is accepted only when the queue had room
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !res_valid)
		else $error("result produced while queue full");
`endif

endmodule

>>> dv/tb_id3v2_tag_parser.sv
`timescale 1ns / 100ps

module tb_id3v2_tag_parser;

	// Magic letters and prefix lengths, kept locally so that the prediction
	// does not lean on the package helpers.
	localparam logic [7:0] TAG_MAGIC [3] = '{8'h49, 8'h44, 8'h33};
	localparam logic [1:0] PREFIX_BYTES [4] = '{2'd0, 2'd2, 2'd2, 2'd3};
	localparam logic [7:0] TAG_V3 = 8'h03;
	localparam int         DRAIN_CYCLES = 6;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        push = 1'b0;
	logic        full;
	logic [7:0]  data_byte = 8'h00;
	logic        restart = 1'b0;
	logic        cfg_we = 1'b0;
	logic        cfg_data = 1'b0;
	logic        empty;
	logic        pop = 1'b0;
	logic [2:0]  kind;
	logic [7:0]  version;
	logic [7:0]  revision;
	logic [2:0]  header_flags;
	logic [31:0] size_value;
	logic [31:0] frame_ident;
	logic [1:0]  text_encoding;
	logic [7:0]  out_byte;
	logic        last_of_frame;

	id3v2_tag_parser u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.push          (push),
		.full          (full),
		.data_byte     (data_byte),
		.restart       (restart),
		.cfg_we        (cfg_we),
		.cfg_data      (cfg_data),
		.empty         (empty),
		.pop           (pop),
		.kind          (kind),
		.version       (version),
		.revision      (revision),
		.header_flags  (header_flags),
		.size_value    (size_value),
		.frame_ident   (frame_ident),
		.text_encoding (text_encoding),
		.out_byte      (out_byte),
		.last_of_frame (last_of_frame)
	);

	always #1 clk = ~clk;

	// Hard stop in case the block hangs or stops producing results.
	initial begin
		#1_000_000;
		$display("Verification failed");
		$finish;
	end

	// ------------------------------------------------------------------
	// Parser prediction: own copy of the configuration and parse state.
	// ------------------------------------------------------------------
	logic             emit_on;
	id3_pkg::phase_t  ph;
	logic [3:0]       hdr_idx;
	logic [27:0]      tag_left;
	logic [31:0]      frame_left;
	logic [31:0]      frame_id;
	logic [31:0]      frame_size;
	logic [1:0]       enc;
	logic [1:0]       prefix_left;
	logic [7:0]       ver_q;
	logic [7:0]       rev_q;
	logic [2:0]       flags_q;
	logic             magic_ok;

	id3_pkg::res_t expected_records[$];
	int   fail_count = 0;
	int   burst_left = 0;
	int   bytes_sent = 0;

	task automatic clear_parse_state();
		ph = id3_pkg::PH_HDR;
		hdr_idx = '0;
		tag_left = '0;
		frame_left = '0;
		frame_id = '0;
		frame_size = '0;
		enc = '0;
		prefix_left = '0;
		ver_q = '0;
		rev_q = '0;
		flags_q = '0;
		magic_ok = 1'b1;
	endtask

	// Advance the parse state by one file byte; queue the record it yields.
	task automatic decode_byte(input logic [7:0] b, input logic rs);
		id3_pkg::res_t rec;
		logic [2:0]    k;
		logic [31:0]   sz;
		logic          have, with_frame, with_byte, last, payload_out, in_tag;

		k = id3_pkg::KIND_HEADER;
		sz = '0;
		have = 1'b0;
		with_frame = 1'b0;
		with_byte = 1'b0;
		last = 1'b0;
		payload_out = 1'b0;
		in_tag = 1'b0;
		if (rs)
			clear_parse_state();

		case (ph)
		id3_pkg::PH_HDR: begin
			if (hdr_idx < id3_pkg::IDX_VERSION) begin
				if (b != TAG_MAGIC[hdr_idx[1:0]])
					magic_ok = 1'b0;
			end else if (hdr_idx == id3_pkg::IDX_VERSION) begin
				ver_q = b;
			end else if (hdr_idx == id3_pkg::IDX_REVISION) begin
				rev_q = b;
			end else if (hdr_idx == id3_pkg::IDX_FLAGS) begin
				flags_q = b[7:5];
			end else begin
				// syncsafe: seven bits per size byte
				tag_left = (tag_left << 7) | 28'(b & id3_pkg::SYNCSAFE_MASK);
			end
			if (hdr_idx >= id3_pkg::HDR_LAST_IDX) begin
				hdr_idx = '0;
				have = 1'b1;
				if (!magic_ok) begin
					k = id3_pkg::KIND_NOTAG;
					ph = id3_pkg::PH_PASS;
				end else begin
					k = id3_pkg::KIND_HEADER;
					sz = 32'(tag_left);
					if (tag_left == '0)
						ph = id3_pkg::PH_PASS;
					else
						ph = (ver_q == TAG_V3) ? id3_pkg::PH_FHDR : id3_pkg::PH_SKIP;
				end
			end else begin
				hdr_idx++;
			end
		end
		id3_pkg::PH_FHDR: begin
			in_tag = 1'b1;
			if (hdr_idx < id3_pkg::IDX_ID_END)
				frame_id = {frame_id[23:0], b};
			else if (hdr_idx < id3_pkg::IDX_SIZE_END)
				frame_size = {frame_size[23:0], b};
			if (hdr_idx >= id3_pkg::HDR_LAST_IDX) begin
				hdr_idx = '0;
				if (frame_size == '0) begin
					// padding: report it, then skip the rest of the tag until its end
					k = id3_pkg::KIND_PAD;
					have = 1'b1;
					with_frame = 1'b1;
					ph = id3_pkg::PH_SKIP;
				end else begin
					ph = id3_pkg::PH_ENC;
				end
			end else begin
				hdr_idx++;
			end
		end
		id3_pkg::PH_ENC: begin
			if (b > id3_pkg::MAX_ENCODING) begin
				// bad encoding wins over tag end and halts until restart
				k = id3_pkg::KIND_BADENC;
				have = 1'b1;
				with_frame = 1'b1;
				with_byte = 1'b1;
				ph = id3_pkg::PH_STOP;
			end else begin
				in_tag = 1'b1;
				enc = b[1:0];
				prefix_left = PREFIX_BYTES[b[1:0]];
				frame_left = frame_size - 32'd1;
				k = id3_pkg::KIND_FSTART;
				sz = frame_size;
				have = 1'b1;
				with_frame = 1'b1;
				ph = (frame_left == '0) ? id3_pkg::PH_FHDR : id3_pkg::PH_BODY;
			end
		end
		id3_pkg::PH_BODY: begin
			in_tag = 1'b1;
			if (frame_left != '0)
				frame_left--;
			if (prefix_left != '0) begin
				prefix_left--;
			end else if (emit_on) begin
				k = id3_pkg::KIND_PAYLOAD;
				have = 1'b1;
				with_frame = 1'b1;
				with_byte = 1'b1;
				payload_out = 1'b1;
				last = (frame_left == '0);
			end
			if (frame_left == '0) begin
				hdr_idx = '0;
				ph = id3_pkg::PH_FHDR;
			end
		end
		id3_pkg::PH_SKIP: in_tag = 1'b1;
		id3_pkg::PH_PASS: begin
			k = id3_pkg::KIND_PASS;
			have = 1'b1;
			with_byte = 1'b1;
		end
		default: ;
		endcase

		// The byte that uses up the tag count replaces any other record.
		if (in_tag) begin
			if (tag_left != '0)
				tag_left--;
			if (tag_left == '0) begin
				k = id3_pkg::KIND_TAGEND;
				have = 1'b1;
				with_frame = 1'b1;
				with_byte = 1'b1;
				sz = '0;
				last = payload_out;
				ph = id3_pkg::PH_PASS;
			end
		end

		if (have) begin
			rec.kind = k;
			rec.version = ver_q;
			rec.revision = rev_q;
			rec.header_flags = flags_q;
			rec.size_value = sz;
			rec.frame_ident = with_frame ? frame_id : '0;
			rec.text_encoding = with_frame ? enc : '0;
			rec.out_byte = with_byte ? b : '0;
			rec.last_of_frame = last;
			expected_records.push_back(rec);
		end
	endtask

	// ------------------------------------------------------------------
	// Result side: stall on a rotating pattern and check each popped item.
	// ------------------------------------------------------------------
	int unsigned   stall_tick = 0;
	id3_pkg::res_t want;

	task automatic check_field(input string name, input logic [31:0] exp_v,
		input logic [31:0] act_v);
		if (exp_v !== act_v) begin
			$display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name,
				exp_v, act_v);
			fail_count++;
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && pop && !empty) begin
			if (expected_records.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual kind %0d", $time,
					kind);
				fail_count++;
			end else begin
				want = expected_records.pop_front();
				check_field("kind", 32'(want.kind), 32'(kind));
				check_field("version", 32'(want.version), 32'(version));
				check_field("revision", 32'(want.revision), 32'(revision));
				check_field("header_flags", 32'(want.header_flags), 32'(header_flags));
				check_field("size_value", want.size_value, size_value);
				check_field("frame_ident", want.frame_ident, frame_ident);
				check_field("text_encoding", 32'(want.text_encoding),
					32'(text_encoding));
				check_field("out_byte", 32'(want.out_byte), 32'(out_byte));
				check_field("last_of_frame", 32'(want.last_of_frame),
					32'(last_of_frame));
			end
		end
		// Rotate through: always ready, mostly ready, mostly stalled, long stalls.
		stall_tick++;
		case ((stall_tick >> 7) % 4)
		0: pop <= 1'b1;
		1: pop <= ($urandom_range(0, 3) != 0);
		2: pop <= ($urandom_range(0, 3) == 0);
		default: pop <= (stall_tick[4:0] < 5'd4);
		endcase
	end

	// ------------------------------------------------------------------
	// Input side.
	// ------------------------------------------------------------------

	// Hold one byte on the inputs until it is taken, then maybe pause.
	task automatic send_byte(input logic [7:0] b, input logic rs);
		int gap;

		push <= 1'b1;
		data_byte <= b;
		restart <= rs;
		do
			@(posedge clk);
		while (full);
		decode_byte(b, rs);
		bytes_sent++;
		burst_left--;
		if (burst_left <= 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
			if (gap > 0) begin
				push <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	// Send a byte sequence; the first byte optionally starts a new file.
	task automatic send_seq(input logic [7:0] seq[$], input logic first_restart);
		foreach (seq[i])
			send_byte(seq[i], first_restart && (i == 0));
	endtask

	// Drop push and wait until every expected item is out and the parser
	// has settled, so the register can be written safely.
	task automatic go_idle();
		push <= 1'b0;
		while (expected_records.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_emit(input logic val);
		go_idle();
		cfg_we <= 1'b1;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		emit_on = val;
	endtask

	// Build one random file: mostly v3 tags with random content,
	// plus noise, broken magic, other versions and truncated files.
	task automatic send_random_file();
		logic [7:0]  file_q[$];
		logic [7:0]  body_q[$];
		logic [7:0]  ver;
		logic [27:0] tag_size;
		logic [31:0] fsize;
		int          pick, fpick, nframes, keep;
		bit          stop_frames;
		bit          with_restart;

		pick = $urandom_range(0, 99);
		with_restart = ($urandom_range(0, 9) != 0);
		ver = TAG_V3;
		if (pick < 8) begin
			repeat (10) file_q.push_back(8'($urandom));
		end else begin
			file_q = {TAG_MAGIC[0], TAG_MAGIC[1], TAG_MAGIC[2]};
			if (pick < 14) begin
				file_q[$urandom_range(0, 2)] ^= 8'($urandom_range(1, 255));
			end else if (pick < 26) begin
				ver = 8'($urandom);
				if (ver == TAG_V3)
					ver = 8'h04;
			end
			file_q.push_back(ver);

			if (ver != TAG_V3) begin
				repeat ($urandom_range(0, 12)) body_q.push_back(8'($urandom));
			end else begin
				nframes = $urandom_range(1, 3);
				stop_frames = 1'b0;
				for (int f = 0; f < nframes && !stop_frames; f++) begin
					fpick = $urandom_range(0, 99);
					if (fpick < 8) begin
						// padding area
						repeat ($urandom_range(10, 16)) body_q.push_back(8'h00);
						stop_frames = 1'b1;
					end else begin
						repeat (4)
							body_q.push_back(($urandom_range(0, 3) == 0) ?
								8'($urandom) : 8'($urandom_range(8'h41, 8'h5a)));
						// huge sizes only ever end by tag count or restart
						fsize = (fpick < 16) ? 32'($urandom) : 32'($urandom_range(1, 9));
						for (int s = 3; s >= 0; s--)
							body_q.push_back(fsize[8*s +: 8]);
						repeat (2) body_q.push_back(8'($urandom));
						if (fpick >= 16 && fpick < 22) begin
							body_q.push_back(8'($urandom_range(4, 255)));
							repeat ($urandom_range(0, 3)) body_q.push_back(8'($urandom));
							stop_frames = 1'b1;
						end else begin
							body_q.push_back(8'($urandom_range(0, 3)));
							repeat ((fsize > 32'd10) ? 10 : int'(fsize) - 1)
								body_q.push_back(8'($urandom));
							if (fpick < 16)
								stop_frames = 1'b1;
						end
					end
				end
			end

			// Tag size: empty, exact (maybe with zero fill), cut short, or oversized.
			pick = $urandom_range(0, 9);
			if (pick == 0) begin
				tag_size = '0;
			end else if (pick < 5) begin
				repeat ($urandom_range(0, 3)) body_q.push_back(8'h00);
				tag_size = 28'(body_q.size());
			end else if (pick < 8) begin
				tag_size = 28'($urandom_range(1, (body_q.size() > 0) ? body_q.size() : 1));
			end else if (pick == 8) begin
				tag_size = 28'(body_q.size() + $urandom_range(1, 1000));
			end else begin
				tag_size = '1;
			end

			file_q.push_back(8'($urandom));
			file_q.push_back(8'($urandom));
			// top bit of each size byte is random; the block must mask it
			for (int s = 3; s >= 0; s--)
				file_q.push_back({1'($urandom), tag_size[7*s +: 7]});
			file_q = {file_q, body_q};
		end
		repeat ($urandom_range(0, 4)) file_q.push_back(8'($urandom));

		// Truncate some files so the next restart lands mid-parse.
		if ($urandom_range(0, 9) == 0) begin
			keep = $urandom_range(1, file_q.size());
			while (file_q.size() > keep)
				void'(file_q.pop_back());
		end
		send_seq(file_q, with_restart);
	endtask

	// ------------------------------------------------------------------
	// Tests.
	// ------------------------------------------------------------------

	// Header of all ones fails the magic check; later bytes pass through.
	task automatic test_no_tag();
		logic [7:0] seq[$];

		repeat (10) seq.push_back(8'hff);
		seq.push_back(8'h00);
		send_seq(seq, 1'b1);
	endtask

	// Zero tag size: the byte right after the header already passes through.
	task automatic test_empty_tag();
		logic [7:0] seq[$];

		seq = {TAG_MAGIC[0], TAG_MAGIC[1], TAG_MAGIC[2], TAG_V3, 8'h00, 8'he0,
			8'h00, 8'h00, 8'h00, 8'h00, 8'h5a};
		send_seq(seq, 1'b1);
	endtask

	// Largest tag and frame sizes, then an out-of-range encoding; the byte
	// after the bad encoding must give nothing.
	task automatic test_bad_encoding();
		logic [7:0] seq[$];

		seq = {TAG_MAGIC[0], TAG_MAGIC[1], TAG_MAGIC[2], TAG_V3, 8'hff, 8'hff};
		repeat (16) seq.push_back(8'hff);
		seq.push_back(8'h00);
		send_seq(seq, 1'b1);
	endtask

	task automatic test_random_stream(input logic emit_val, input int n_bytes);
		int stop_at;

		write_emit(emit_val);
		stop_at = bytes_sent + n_bytes;
		while (bytes_sent < stop_at)
			send_random_file();
	endtask

	initial begin
		emit_on = 1'b1;
		clear_parse_state();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		test_no_tag();
		test_empty_tag();
		test_bad_encoding();
		test_random_stream(1'b1, 300);
		test_random_stream(1'b0, 250);
		test_random_stream(1'b1, 300);

		go_idle();
		// anything still waiting now is a result that was never predicted
		if (!empty) begin
			$display("%0t: leftover result, expected none, actual kind %0d", $time,
				kind);
			fail_count++;
		end
		if (fail_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

>>> sim.f
rtl/id3_pkg.sv
rtl/id3_front.sv
rtl/id3_queue.sv
rtl/id3v2_tag_parser.sv
dv/tb_id3v2_tag_parser.sv
